FILE: rtl/dlf_pkg.sv
// shared types and constants for the dense layer forward block
package dlf_pkg;

    // input item modes
    localparam logic [1:0] MODE_WEIGHT = 2'd0;
    localparam logic [1:0] MODE_BIAS   = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_IN_COUNT    = 2'd0;
    localparam logic [1:0] REG_OUT_COUNT   = 2'd1;
    localparam logic [1:0] REG_RELU_ENABLE = 2'd2;

    localparam int unsigned CNT_W      = 5;
    localparam logic [4:0]  IN_COUNT_RST  = 5'd16;
    localparam logic [4:0]  OUT_COUNT_RST = 5'd16;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
        logic signed [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         out_index;
        logic signed [15:0] out_value;
        logic               saturated;
        logic               last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic weight_wr;
        logic bias_wr;
        logic sample_wr;
        logic mac_valid;
        logic mac_first;
        logic mac_last;
        logic emit;
        logic emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic acc_full;
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/dlf_ctrl.sv
// controller: element counting, mac sequencing and result emission
module dlf_ctrl #(
    parameter int IN_MAX  = 16,
    parameter int OUT_MAX = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [1:0]            i_mode,
    input  logic [dlf_pkg::CNT_W-1:0] i_in_count,
    input  logic [dlf_pkg::CNT_W-1:0] i_out_count,
    input  dlf_pkg::t_dp_status   i_status,
    output logic                  o_in_stall,
    output dlf_pkg::t_dp_cmd      o_cmd,
    output logic [((IN_MAX > 1) ? $clog2(IN_MAX) : 1)-1:0]   o_elem_idx,
    output logic [((IN_MAX > 1) ? $clog2(IN_MAX) : 1)-1:0]   o_k,
    output logic [((OUT_MAX > 1) ? $clog2(OUT_MAX) : 1)-1:0] o_j
);

    localparam int KW     = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int JW     = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int CW_IN  = $clog2(IN_MAX + 1);
    localparam int CW_OUT = $clog2(OUT_MAX + 1);

    dlf_pkg::t_state r_state, n_state;
    logic [KW-1:0]     r_elem_cnt, n_elem_cnt;
    logic [KW-1:0]     r_k, n_k;
    logic [JW-1:0]     r_j, n_j;
    logic [CW_IN-1:0]  n_in;
    logic [CW_OUT-1:0] n_out;
    logic              accept;
    logic              sample_done;
    logic              k_last;
    logic              j_last;

    // zero acts as one, values above the maximum act as the maximum
    always_comb begin
        if (i_in_count == '0) begin
            n_in = CW_IN'(1);
        end else if (32'(i_in_count) > IN_MAX) begin
            n_in = CW_IN'(IN_MAX);
        end else begin
            n_in = CW_IN'(i_in_count);
        end
        if (i_out_count == '0) begin
            n_out = CW_OUT'(1);
        end else if (32'(i_out_count) > OUT_MAX) begin
            n_out = CW_OUT'(OUT_MAX);
        end else begin
            n_out = CW_OUT'(i_out_count);
        end
    end

    assign accept      = i_in_valid && (r_state == dlf_pkg::S_IDLE);
    assign sample_done = (CW_IN'(r_elem_cnt) + CW_IN'(1)) >= n_in;
    assign k_last      = (CW_IN'(r_k) + CW_IN'(1)) == n_in;
    assign j_last      = (CW_OUT'(r_j) + CW_OUT'(1)) == n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dlf_pkg::S_IDLE;
            r_elem_cnt <= '0;
            r_k        <= '0;
            r_j        <= '0;
        end else begin
            r_state    <= n_state;
            r_elem_cnt <= n_elem_cnt;
            r_k        <= n_k;
            r_j        <= n_j;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_elem_cnt = r_elem_cnt;
        n_k        = r_k;
        n_j        = r_j;
        o_cmd      = '0;
        unique case (r_state)
            dlf_pkg::S_IDLE: begin
                if (accept) begin
                    o_cmd.weight_wr = (i_mode == dlf_pkg::MODE_WEIGHT);
                    o_cmd.bias_wr   = (i_mode == dlf_pkg::MODE_BIAS);
                    o_cmd.sample_wr = (i_mode == dlf_pkg::MODE_SAMPLE);
                    if (i_mode == dlf_pkg::MODE_SAMPLE) begin
                        if (sample_done) begin
                            n_elem_cnt = '0;
                            n_k        = '0;
                            n_j        = '0;
                            n_state    = dlf_pkg::S_MAC;
                        end else begin
                            n_elem_cnt = r_elem_cnt + KW'(1);
                        end
                    end
                end
            end
            dlf_pkg::S_MAC: begin
                o_cmd.mac_valid = 1'b1;
                o_cmd.mac_first = (r_k == '0);
                o_cmd.mac_last  = k_last;
                if (k_last) begin
                    n_k     = '0;
                    n_state = dlf_pkg::S_FINISH;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            dlf_pkg::S_FINISH: begin
                // wait for a finished sum in the accumulator and for the output slot to free up
                if (i_status.acc_full && i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = j_last;
                    if (j_last) begin
                        n_j     = '0;
                        n_state = dlf_pkg::S_IDLE;
                    end else begin
                        n_j     = r_j + JW'(1);
                        n_state = dlf_pkg::S_MAC;
                    end
                end
            end
            default: begin
                n_state = dlf_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != dlf_pkg::S_IDLE);
    assign o_elem_idx = r_elem_cnt;
    assign o_k        = r_k;
    assign o_j        = r_j;

    a_last_emit_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit && o_cmd.emit_last |=> r_state == dlf_pkg::S_IDLE)
        else $error("block not idle after last result of a sample");

    a_elem_cnt_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != dlf_pkg::S_IDLE |-> r_elem_cnt == '0)
        else $error("element count not cleared while a sample is processed");

    a_mac_k_zero_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dlf_pkg::S_FINISH |-> r_k == '0)
        else $error("mac counter not rewound before finishing a neuron");

endmodule

FILE: rtl/dlf_datapath.sv
// datapath: weight, bias and sample stores, shared mac, result formatting
module dlf_datapath #(
    parameter int IN_MAX    = 16,
    parameter int OUT_MAX   = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dlf_pkg::t_dp_cmd     i_cmd,
    output dlf_pkg::t_dp_status  o_status,
    input  dlf_pkg::t_in_item    i_item,
    input  logic [((IN_MAX > 1) ? $clog2(IN_MAX) : 1)-1:0]   i_elem_idx,
    input  logic [((IN_MAX > 1) ? $clog2(IN_MAX) : 1)-1:0]   i_k,
    input  logic [((OUT_MAX > 1) ? $clog2(OUT_MAX) : 1)-1:0] i_j,
    input  logic                 i_relu,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output dlf_pkg::t_out_item   o_out_item
);

    localparam int KW    = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int JW    = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int WN    = IN_MAX * OUT_MAX;
    localparam int WAW   = (WN > 1) ? $clog2(WN) : 1;
    localparam int ACC_W = 32 + KW;
    localparam logic signed [ACC_W:0] SAT_MAX = (ACC_W + 1)'(32767);
    localparam logic signed [ACC_W:0] SAT_MIN = -(ACC_W + 1)'(32768);

    logic signed [15:0] weight_mem [0:WN-1];
    logic signed [15:0] bias_mem   [0:OUT_MAX-1];
    logic signed [15:0] sample_mem [0:IN_MAX-1];

    logic [WAW-1:0]     w_waddr;
    logic [WAW-1:0]     w_raddr;
    logic               w_in_range;
    logic               b_in_range;

    logic signed [15:0] r_w_q;
    logic signed [15:0] r_x_q;
    logic signed [15:0] r_bias;
    logic               r_a_vld, r_a_first, r_a_last;
    logic signed [31:0] r_prod;
    logic               r_b_vld, r_b_first, r_b_last;
    logic signed [ACC_W-1:0] r_acc;
    logic               r_acc_full;
    logic               r_out_valid;
    dlf_pkg::t_out_item r_out;

    logic signed [ACC_W-1:0] acc_sh;
    logic signed [ACC_W:0]   y_sum;
    logic signed [ACC_W:0]   y_relu;
    logic signed [15:0]      y_sat;
    logic                    sat;
    logic                    out_free;

    assign w_in_range = (32'(i_item.row_index) < IN_MAX) && (32'(i_item.col_index) < OUT_MAX);
    assign b_in_range = (32'(i_item.col_index) < OUT_MAX);
    assign w_waddr    = WAW'(32'(i_item.row_index) * OUT_MAX + 32'(i_item.col_index));
    assign w_raddr    = WAW'(32'(i_k) * OUT_MAX + 32'(i_j));

    // stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.weight_wr && w_in_range) begin
            weight_mem[w_waddr] <= i_item.value;
        end
        r_w_q <= weight_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bias_wr && b_in_range) begin
            bias_mem[JW'(i_item.col_index)] <= i_item.value;
        end
        r_bias <= bias_mem[i_j];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sample_wr) begin
            sample_mem[i_elem_idx] <= i_item.value;
        end
        r_x_q <= sample_mem[i_k];
    end

    // mac pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= r_x_q * r_w_q;
        if (r_b_vld) begin
            r_acc <= r_b_first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_a_first  <= 1'b0;
            r_a_last   <= 1'b0;
            r_b_vld    <= 1'b0;
            r_b_first  <= 1'b0;
            r_b_last   <= 1'b0;
            r_acc_full <= 1'b0;
        end else begin
            r_a_vld   <= i_cmd.mac_valid;
            r_a_first <= i_cmd.mac_first;
            r_a_last  <= i_cmd.mac_last;
            r_b_vld   <= r_a_vld;
            r_b_first <= r_a_first;
            r_b_last  <= r_a_last;
            if (r_b_vld && r_b_last) begin
                r_acc_full <= 1'b1;
            end else if (i_cmd.emit) begin
                r_acc_full <= 1'b0;
            end
        end
    end

    // arithmetic shift floors; relu comes before saturation
    always_comb begin
        acc_sh = r_acc >>> FRAC_BITS;
        y_sum  = (ACC_W + 1)'(acc_sh) + (ACC_W + 1)'(r_bias);
        y_relu = (i_relu && y_sum < 0) ? '0 : y_sum;
        if (y_relu > SAT_MAX) begin
            y_sat = 16'sh7fff;
            sat   = 1'b1;
        end else if (y_relu < SAT_MIN) begin
            y_sat = -16'sh8000;
            sat   = 1'b1;
        end else begin
            y_sat = y_relu[15:0];
            sat   = 1'b0;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_index <= 4'(i_j);
            r_out.out_value <= y_sat;
            r_out.saturated <= sat;
            r_out.last      <= i_cmd.emit_last;
        end
    end

    assign o_status.acc_full = r_acc_full;
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out;

    a_emit_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_acc_full && out_free)
        else $error("result emitted before accumulator or output slot was ready");

    a_no_mac_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mac_valid |-> !r_acc_full)
        else $error("new mac started while a finished sum is pending");

    a_stalled_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed or dropped");

endmodule

FILE: rtl/dense_layer_forward_top.sv
// Fully connected layer with optional relu, signed Q8.8, one shared mac unit.
// Weight, bias and non-final sample transfers are taken without stalling; the final
// element of a sample stalls the input while each of the out_count neurons is computed:
// a mac over the n_in elements on the single mac unit per neuron, then multiply and accumulate
// stages and an emit, held longer while a result is stalled.
// Reset clears control state and loads the register reset values; stores are not cleared.
module dense_layer_forward_top #(
    parameter int IN_MAX    = 16,
    parameter int OUT_MAX   = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dlf_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dlf_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int KW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int JW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;

    logic [dlf_pkg::CNT_W-1:0] r_in_count;
    logic [dlf_pkg::CNT_W-1:0] r_out_count;
    logic                      r_relu_enable;
    logic                      cfg_wr;
    logic [1:0]                cfg_idx;

    dlf_pkg::t_dp_cmd    cmd;
    dlf_pkg::t_dp_status status;
    logic [KW-1:0]       elem_idx;
    logic [KW-1:0]       k_idx;
    logic [JW-1:0]       j_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_count    <= dlf_pkg::IN_COUNT_RST;
            r_out_count   <= dlf_pkg::OUT_COUNT_RST;
            r_relu_enable <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                dlf_pkg::REG_IN_COUNT:    r_in_count    <= pwdata[dlf_pkg::CNT_W-1:0];
                dlf_pkg::REG_OUT_COUNT:   r_out_count   <= pwdata[dlf_pkg::CNT_W-1:0];
                dlf_pkg::REG_RELU_ENABLE: r_relu_enable <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            dlf_pkg::REG_IN_COUNT:    prdata = 32'(r_in_count);
            dlf_pkg::REG_OUT_COUNT:   prdata = 32'(r_out_count);
            dlf_pkg::REG_RELU_ENABLE: prdata = 32'(r_relu_enable);
            default:                  prdata = '0;
        endcase
    end

    dlf_ctrl #(
        .IN_MAX  (IN_MAX),
        .OUT_MAX (OUT_MAX)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_in_item.mode),
        .i_in_count  (r_in_count),
        .i_out_count (r_out_count),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd),
        .o_elem_idx  (elem_idx),
        .o_k         (k_idx),
        .o_j         (j_idx)
    );

    dlf_datapath #(
        .IN_MAX    (IN_MAX),
        .OUT_MAX   (OUT_MAX),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item      (i_in_item),
        .i_elem_idx  (elem_idx),
        .i_k         (k_idx),
        .i_j         (j_idx),
        .i_relu      (r_relu_enable),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
